@@ src/sbo_pkg.sv @@
package sbo_pkg;

  // Default coordinate width: signed Q16.16.
  localparam int COORD_WIDTH_DEF = 32;

  // Doubled differences (centre offset, half vector, half size) carry two extra bits.
  localparam int DIFF_WIDTH_DEF = COORD_WIDTH_DEF + 2;

endpackage

@@ src/sbo_seg_if.sv @@
interface sbo_seg_if
  import sbo_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] seg_start_x;
  logic signed [COORD_WIDTH-1:0] seg_start_y;
  logic signed [COORD_WIDTH-1:0] seg_start_z;
  logic signed [COORD_WIDTH-1:0] seg_end_x;
  logic signed [COORD_WIDTH-1:0] seg_end_y;
  logic signed [COORD_WIDTH-1:0] seg_end_z;
  logic signed [COORD_WIDTH-1:0] box_min_x;
  logic signed [COORD_WIDTH-1:0] box_min_y;
  logic signed [COORD_WIDTH-1:0] box_min_z;
  logic signed [COORD_WIDTH-1:0] box_max_x;
  logic signed [COORD_WIDTH-1:0] box_max_y;
  logic signed [COORD_WIDTH-1:0] box_max_z;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_start_z,
           seg_end_x, seg_end_y, seg_end_z,
           box_min_x, box_min_y, box_min_z,
           box_max_x, box_max_y, box_max_z,
    input  ready
  );

  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_start_z,
           seg_end_x, seg_end_y, seg_end_z,
           box_min_x, box_min_y, box_min_z,
           box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

@@ src/sbo_hit_if.sv @@
interface sbo_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

@@ src/segment_box_overlap_test_top.sv @@
// Channel   Modport   Direction  Payload
// seg_in    sink      input      segment start/end, box min/max (signed, COORD_WIDTH each)
// hit_out   source    output     hit (1 bit)
//
// Five register stages: inputs to doubled differences and endpoint tests, axis
// tests and partial products, full products, cross terms, abs compare into the
// output register. One item is taken every cycle unless a stall on hit_out backs up to stage 1.
// Reset (synchronous, rst) clears only the stage valid bits and keeps seg_in.ready low.
// Each stage holds only while its own item waits on the next one, so bubbles
// collapse and a stall on hit_out loses and repeats nothing.
module segment_box_overlap_test_top
  import sbo_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sbo_seg_if.sink     seg_in,
  sbo_hit_if.source   hit_out
);
  localparam int W  = COORD_WIDTH;
  localparam int WM = W + 2;       // doubled differences
  localparam int WA = W + 3;       // axis test sums
  localparam int WP = 2 * WM;      // products
  localparam int WS = WP + 1;      // sums of two products

  // Stage valid bits and enables. A stage loads when it is empty or when
  // the stage after it loads too.
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5 || hit_out.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  // No item is taken while reset is held, since stage 1 drops it then.
  assign seg_in.ready = en1 && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= seg_in.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Stage 1: per axis, the doubled centre offset M, the doubled half vector D,
  // its magnitude L and the doubled box size H, plus the endpoint-in-box tests.
  logic signed [W-1:0]  s_c  [3];
  logic signed [W-1:0]  e_c  [3];
  logic signed [W-1:0]  lo_c [3];
  logic signed [W-1:0]  hi_c [3];
  logic signed [WM-1:0] m_next [3];
  logic signed [WM-1:0] d_next [3];
  logic signed [WM-1:0] l_next [3];
  logic signed [WM-1:0] h_next [3];
  logic [2:0]           s_in, e_in;
  logic                 pt_next;

  assign s_c[0]  = seg_in.seg_start_x;
  assign s_c[1]  = seg_in.seg_start_y;
  assign s_c[2]  = seg_in.seg_start_z;
  assign e_c[0]  = seg_in.seg_end_x;
  assign e_c[1]  = seg_in.seg_end_y;
  assign e_c[2]  = seg_in.seg_end_z;
  assign lo_c[0] = seg_in.box_min_x;
  assign lo_c[1] = seg_in.box_min_y;
  assign lo_c[2] = seg_in.box_min_z;
  assign hi_c[0] = seg_in.box_max_x;
  assign hi_c[1] = seg_in.box_max_y;
  assign hi_c[2] = seg_in.box_max_z;

  logic signed [WM-1:0] m1 [3];
  logic signed [WM-1:0] d1 [3];
  logic signed [WM-1:0] l1 [3];
  logic signed [WM-1:0] h1 [3];
  logic                 pt1;

  for (genvar i = 0; i < 3; i++) begin : g_prep
    always_comb begin
      m_next[i] = WM'(s_c[i]) + WM'(e_c[i]) - WM'(lo_c[i]) - WM'(hi_c[i]);
      d_next[i] = WM'(e_c[i]) - WM'(s_c[i]);
      l_next[i] = (d_next[i] < 0) ? -d_next[i] : d_next[i];
      h_next[i] = WM'(hi_c[i]) - WM'(lo_c[i]);
      // The boundary counts as inside; an inverted box holds no point.
      s_in[i]   = (s_c[i] >= lo_c[i]) && (s_c[i] <= hi_c[i]);
      e_in[i]   = (e_c[i] >= lo_c[i]) && (e_c[i] <= hi_c[i]);
    end

    always_ff @(posedge clk) begin
      if (en1) begin
        m1[i] <= m_next[i];
        d1[i] <= d_next[i];
        l1[i] <= l_next[i];
        h1[i] <= h_next[i];
      end
    end
  end

  assign pt_next = (&s_in) || (&e_in);

  always_ff @(posedge clk) begin
    if (en1) pt1 <= pt_next;
  end

  // Stage 2: the three box-axis tests |M| <= L + H. H may be negative for an
  // inverted box and is used as is. The multipliers form their partial
  // products in the same stage.
  logic signed [WA-1:0] am [3];
  logic signed [WA-1:0] bound [3];
  logic [2:0]           ax_ok;
  logic                 pt2, ax2;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    always_comb begin
      am[i]    = (m1[i] < 0) ? -WA'(m1[i]) : WA'(m1[i]);
      bound[i] = WA'(l1[i]) + WA'(h1[i]);
      ax_ok[i] = !(am[i] > bound[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      pt2 <= pt1;
      ax2 <= &ax_ok;
    end
  end

  // Stages 2 and 3: for each axis pair (a, b) = (x,y), (y,z), (z,x) the four
  // products M_a*D_b, M_b*D_a, H_a*L_b and H_b*L_a.
  logic signed [WP-1:0] p_md [3];
  logic signed [WP-1:0] p_dm [3];
  logic signed [WP-1:0] p_hl [3];
  logic signed [WP-1:0] p_lh [3];
  logic                 pt3, ax3;

  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int A = i;
    localparam int B = (i + 1) % 3;

    sbo_mul #(.WIDTH(WM)) u_mul_md (
      .clk     (clk),
      .en_part (en2),
      .en_sum  (en3),
      .a       (m1[A]),
      .b       (d1[B]),
      .p       (p_md[i])
    );

    sbo_mul #(.WIDTH(WM)) u_mul_dm (
      .clk     (clk),
      .en_part (en2),
      .en_sum  (en3),
      .a       (m1[B]),
      .b       (d1[A]),
      .p       (p_dm[i])
    );

    sbo_mul #(.WIDTH(WM)) u_mul_hl (
      .clk     (clk),
      .en_part (en2),
      .en_sum  (en3),
      .a       (h1[A]),
      .b       (l1[B]),
      .p       (p_hl[i])
    );

    sbo_mul #(.WIDTH(WM)) u_mul_lh (
      .clk     (clk),
      .en_part (en2),
      .en_sum  (en3),
      .a       (h1[B]),
      .b       (l1[A]),
      .p       (p_lh[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      pt3 <= pt2;
      ax3 <= ax2;
    end
  end

  // Stage 4: the cross-axis projections of the offset and of the bound.
  logic signed [WS-1:0] lhs4 [3];
  logic signed [WS-1:0] rhs4 [3];
  logic                 pt4, ax4;

  for (genvar i = 0; i < 3; i++) begin : g_terms
    always_ff @(posedge clk) begin
      if (en4) begin
        lhs4[i] <= WS'(p_md[i]) - WS'(p_dm[i]);
        rhs4[i] <= WS'(p_hl[i]) + WS'(p_lh[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      pt4 <= pt3;
      ax4 <= ax3;
    end
  end

  // Stage 5: a cross axis separates when |lhs| > |rhs|. The bound takes the
  // magnitude of the whole sum, which matters only for inverted boxes.
  logic [WS-1:0] lhs_mag [3];
  logic [WS-1:0] rhs_mag [3];
  logic [2:0]    cr_ok;
  logic          hit_next;
  logic          hit_q;

  for (genvar i = 0; i < 3; i++) begin : g_cmp
    always_comb begin
      lhs_mag[i] = (lhs4[i] < 0) ? WS'(-lhs4[i]) : WS'(lhs4[i]);
      rhs_mag[i] = (rhs4[i] < 0) ? WS'(-rhs4[i]) : WS'(rhs4[i]);
      cr_ok[i]   = !(lhs_mag[i] > rhs_mag[i]);
    end
  end

  assign hit_next = pt4 || (ax4 && (&cr_ok));

  always_ff @(posedge clk) begin
    if (en5) hit_q <= hit_next;
  end

  assign hit_out.valid = v5;
  assign hit_out.hit   = hit_q;
endmodule

@@ src/sbo_mul.sv @@
// Two-stage signed multiplier. Both operands are split into a signed upper
// half and an unsigned lower half; the four partial products are registered
// and then summed into the full product.
module sbo_mul
  import sbo_pkg::*;
#(
  parameter int WIDTH = DIFF_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      en_part,
  input  logic                      en_sum,
  input  logic signed [WIDTH-1:0]   a,
  input  logic signed [WIDTH-1:0]   b,
  output logic signed [2*WIDTH-1:0] p
);
  localparam int KL = WIDTH / 2;
  localparam int KH = WIDTH - KL;
  localparam int WP = 2 * WIDTH;

  logic signed [KH-1:0]      a_hi, b_hi;
  logic signed [KL:0]        a_lo, b_lo;
  logic signed [2*KH-1:0]    pp_hh;
  logic signed [KH+KL:0]     pp_hl;
  logic signed [KH+KL:0]     pp_lh;
  logic signed [2*KL+1:0]    pp_ll;
  logic signed [WP-1:0]      sum_next;

  // Lower halves get a zero sign bit so every partial product is signed.
  assign a_hi = a[WIDTH-1:KL];
  assign b_hi = b[WIDTH-1:KL];
  assign a_lo = $signed({1'b0, a[KL-1:0]});
  assign b_lo = $signed({1'b0, b[KL-1:0]});

  always_ff @(posedge clk) begin
    if (en_part) begin
      pp_hh <= a_hi * b_hi;
      pp_hl <= a_hi * b_lo;
      pp_lh <= a_lo * b_hi;
      pp_ll <= a_lo * b_lo;
    end
  end

  assign sum_next = (WP'(pp_hh) <<< (2 * KL))
                  + (WP'(pp_hl) <<< KL)
                  + (WP'(pp_lh) <<< KL)
                  + WP'(pp_ll);

  always_ff @(posedge clk) begin
    if (en_sum) begin
      p <= sum_next;
    end
  end
endmodule
